### hw/rtl/tss_pkg.sv
// Shared types, constants and codes of the timed step sequencer.
`timescale 1ns / 1ps
package tss_pkg;

    localparam int STEP_W     = 10;
    localparam int MAX_STEPS  = 1 << STEP_W;
    localparam int COUNT_W    = 11;
    localparam int TIME_W     = 25;
    localparam int REP_W      = 10;
    localparam int CMD_W      = 3;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0]  TIME_LIMIT       = TIME_W'(31536000);
    localparam logic [REP_W-1:0]   REPEAT_LIMIT     = REP_W'(999);
    localparam logic [TIME_W-1:0]  DEFAULT_DURATION = TIME_W'(3600);
    localparam logic [COUNT_W-1:0] COUNT_MAX        = COUNT_W'(MAX_STEPS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_RESUME = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_REPEAT = 3'd4,
        CMD_WRITE  = 3'd5
    } cmd_t;

    typedef enum logic {
        REG_STEP_COUNT = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] seconds;
        logic              auto_step;
        logic [REP_W-1:0]  repeat_value;
        logic [STEP_W-1:0] step_index;
        logic [TIME_W-1:0] duration;
    } item_t;

    typedef struct packed {
        logic [STEP_W-1:0] current_step;
        logic [TIME_W-1:0] elapsed_time;
        logic              running;
        logic              continuing;
        logic [REP_W-1:0]  repeats_left;
        logic              step_finished;
    } status_t;

    typedef struct packed {
        logic              en;
        logic [STEP_W-1:0] addr;
        logic [TIME_W-1:0] data;
    } mem_wr_t;

endpackage

### hw/rtl/tss_step_mem.sv
// Step duration memory with power-up clearing sweep and write-first read.
`timescale 1ns / 1ps
module tss_step_mem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tss_pkg::mem_wr_t           wr,
    input  logic [tss_pkg::STEP_W-1:0] raddr,
    output logic [tss_pkg::TIME_W-1:0] rdata,
    output logic                       busy
);
    import tss_pkg::*;

    logic [TIME_W-1:0] mem [MAX_STEPS];
    logic              clr_busy_reg;
    logic [STEP_W-1:0] clr_addr_reg;
    logic [TIME_W-1:0] rdata_reg;
    mem_wr_t           port;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            port.en   = 1'b1;
            port.addr = clr_addr_reg;
            port.data = DEFAULT_DURATION;
        end
        else
        begin
            port = wr;
        end
    end

    // sweep every entry to the default duration after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == STEP_W'(MAX_STEPS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (port.en)
        begin
            mem[port.addr] <= port.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (port.en && (port.addr == raddr))
        begin
            rdata_reg <= port.data;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

### hw/rtl/tss_core.sv
// Sequencer state registers and the command logic for one word.
`timescale 1ns / 1ps
module tss_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        proc_valid,
    input  tss_pkg::item_t              item,
    input  logic [tss_pkg::TIME_W-1:0]  dur,
    input  logic                        cfg_wr,
    input  logic [tss_pkg::COUNT_W-1:0] cfg_value,
    output tss_pkg::status_t            status,
    output tss_pkg::mem_wr_t            mem_wr,
    output logic [tss_pkg::STEP_W-1:0]  raddr,
    output logic [tss_pkg::COUNT_W-1:0] step_count
);
    import tss_pkg::*;

    logic [STEP_W-1:0]  active_reg,  active_next;
    logic [TIME_W-1:0]  elapsed_reg, elapsed_next;
    logic [REP_W-1:0]   repeats_reg, repeats_next;
    logic               run_reg,     run_next;
    logic               cont_reg,    cont_next;
    logic [COUNT_W-1:0] count_reg,   count_next;

    always_comb
    begin
        logic [TIME_W-1:0]  secs_term;
        logic [TIME_W:0]    sum;
        logic               reached;
        logic [COUNT_W-1:0] inc;
        logic               move_req;
        logic               finished;
        logic [COUNT_W-1:0] v;

        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        repeats_next = repeats_reg;
        run_next     = run_reg;
        cont_next    = cont_reg;
        count_next   = count_reg;
        mem_wr       = '0;
        move_req     = 1'b0;
        finished     = 1'b0;
        v            = cfg_value;

        if (cmd_t'(item.command) == CMD_TICK)
        begin
            secs_term = (item.seconds > TIME_LIMIT) ? TIME_LIMIT : item.seconds;
        end
        else
        begin
            secs_term = '0;
        end
        sum     = {1'b0, elapsed_reg} + {1'b0, secs_term};
        reached = (sum >= {1'b0, dur});
        inc     = {1'b0, active_reg} + 1'b1;

        if (proc_valid)
        begin
            unique case (cmd_t'(item.command))
                CMD_TICK:
                begin
                    if (run_reg)
                    begin
                        if (reached)
                        begin
                            elapsed_next = dur;
                            finished     = 1'b1;
                            move_req     = item.auto_step;
                        end
                        else
                        begin
                            elapsed_next = sum[TIME_W-1:0];
                        end
                    end
                end
                CMD_START:
                begin
                    cont_next = 1'b0;
                    if (!run_reg)
                    begin
                        run_next     = 1'b1;
                        active_next  = '0;
                        elapsed_next = '0;
                    end
                end
                CMD_RESUME:
                begin
                    cont_next = 1'b1;
                    if (!run_reg)
                    begin
                        run_next = 1'b1;
                        if (reached)
                        begin
                            elapsed_next = dur;
                            finished     = 1'b1;
                            move_req     = 1'b1;
                        end
                    end
                end
                CMD_STOP:
                begin
                    run_next  = 1'b0;
                    cont_next = 1'b1;
                end
                CMD_REPEAT:
                begin
                    repeats_next = (item.repeat_value > REPEAT_LIMIT) ?
                                   REPEAT_LIMIT : item.repeat_value;
                end
                CMD_WRITE:
                begin
                    if ({1'b0, item.step_index} < count_reg)
                    begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = item.step_index;
                        if (item.duration == '0)
                        begin
                            mem_wr.data = TIME_W'(1);
                        end
                        else if (item.duration > TIME_LIMIT)
                        begin
                            mem_wr.data = TIME_LIMIT;
                        end
                        else
                        begin
                            mem_wr.data = item.duration;
                        end
                        if (item.step_index == active_reg)
                        begin
                            elapsed_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // advance; past the last step wrap and use a repeat, or stop if none left
            if (move_req)
            begin
                elapsed_next = '0;
                if (inc >= count_reg)
                begin
                    active_next = '0;
                    if (repeats_reg != '0)
                    begin
                        repeats_next = repeats_reg - 1'b1;
                    end
                    else
                    begin
                        run_next  = 1'b0;
                        cont_next = 1'b0;
                    end
                end
                else
                begin
                    active_next = inc[STEP_W-1:0];
                end
            end
        end
        else if (cfg_wr && !run_reg)
        begin
            if (v == '0)
            begin
                v = COUNT_W'(1);
            end
            else if (v > COUNT_MAX)
            begin
                v = COUNT_MAX;
            end
            count_next = v;
            if ({1'b0, active_reg} >= v)
            begin
                active_next  = '0;
                elapsed_next = '0;
            end
        end

        status.current_step  = active_next;
        status.elapsed_time  = elapsed_next;
        status.running       = run_next;
        status.continuing    = cont_next;
        status.repeats_left  = repeats_next;
        status.step_finished = finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            elapsed_reg <= '0;
            repeats_reg <= '0;
            run_reg     <= 1'b0;
            cont_reg    <= 1'b1;
            count_reg   <= COUNT_W'(1);
        end
        else
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            repeats_reg <= repeats_next;
            run_reg     <= run_next;
            cont_reg    <= cont_next;
            count_reg   <= count_next;
        end
    end

    assign raddr      = active_next;
    assign step_count = count_reg;

endmodule

### hw/rtl/timed_step_sequencer_unit.sv
// Top level of the timed step sequencer: stream ports, register port, word registers.
`timescale 1ns / 1ps
// An accepted word waits in the input word register; its result is registered in the
// output word register. Throughput: one word per cycle while m_tready is high and no
// clearing pass runs, set by the step state update and the step duration memory read
// for the next active step. Reset: state returns to its reset values at once; then a
// clearing pass fills the 1024 duration memory entries with 3600; s_tready stays low.
module timed_step_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // seconds[24:0], auto_step[25], repeat_value[35:26], step_index[45:36],
    // duration[70:46], unused[71]
    input  logic [tss_pkg::IN_DATA_W-1:0]  s_tdata,
    // command[2:0]
    input  logic [tss_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // current_step[9:0], elapsed_time[34:10], running[35], continuing[36],
    // repeats_left[46:37], step_finished[47]
    output logic [tss_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tss_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [tss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [tss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tss_pkg::*;

    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic                  proc_fire;
    logic                  mem_busy;
    logic                  cfg_sel;
    logic                  cfg_wr;
    status_t               status;
    mem_wr_t               mem_wr;
    logic [STEP_W-1:0]     raddr;
    logic [TIME_W-1:0]     dur;
    logic [COUNT_W-1:0]    step_count;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !mem_busy && (!in_valid_reg || proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
        else if (proc_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.command      <= s_tuser;
            in_item_reg.seconds      <= s_tdata[24:0];
            in_item_reg.auto_step    <= s_tdata[25];
            in_item_reg.repeat_value <= s_tdata[35:26];
            in_item_reg.step_index   <= s_tdata[45:36];
            in_item_reg.duration     <= s_tdata[70:46];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_status_reg <= status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg.step_finished, out_status_reg.repeats_left,
                       out_status_reg.continuing, out_status_reg.running,
                       out_status_reg.elapsed_time, out_status_reg.current_step};

    assign cfg_sel = (reg_idx_t'(paddr[2]) == REG_STEP_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? CFG_DATA_W'(step_count) : '0;

    tss_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .proc_valid (proc_fire),
        .item       (in_item_reg),
        .dur        (dur),
        .cfg_wr     (cfg_wr),
        .cfg_value  (pwdata[COUNT_W-1:0]),
        .status     (status),
        .mem_wr     (mem_wr),
        .raddr      (raddr),
        .step_count (step_count)
    );

    tss_step_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mem_wr),
        .raddr (raddr),
        .rdata (dur),
        .busy  (mem_busy)
    );

endmodule

### hw/rtl/tss_checker.sv
// Port-level checks of the timed step sequencer and their binding to the top level.
`timescale 1ns / 1ps
module tss_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tss_pkg::OUT_DATA_W-1:0] m_tdata
);
    import tss_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result word changed while stalled");

    a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:10] <= TIME_LIMIT))
        else $error("elapsed time beyond the time limit");

    a_repeat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[46:37] <= REPEAT_LIMIT))
        else $error("repeat count beyond its limit");

    a_reset_out: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result word presented straight after reset");

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input taken before the duration memory was cleared");

endmodule

bind timed_step_sequencer_unit tss_checker u_tss_checker (.*);
